/* sv/ssi_pkg.sv */
// Package for the sorted integer set: capacity, widths, command and status codes,
// and the control struct that the top level sends to every cell.
// No dependencies.
`default_nettype none

package ssi_pkg;

  // Number of entries in the store, the count width that follows from it, and the value and output count widths.
  localparam int SET_CAPACITY = 64;
  localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
  localparam int VAL_W        = 32;
  localparam int OUT_CNT_W    = 7;

  // Commands. The unused code acts as a membership query.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_SPARE  = 2'd3
  } ssi_cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CHANGED   = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_FULL      = 2'd2
  } ssi_status_t;

  // Per-cycle control broadcast to the cells.
  typedef struct packed {
    logic cmp;  // compare the stored entry against the broadcast value
    logic ins;  // open a gap at the insert position and write the value
    logic del;  // close the gap at the matching entry
  } ssi_ctl_t;

endpackage

`default_nettype wire

/* sv/sorted_integer_set.sv */
// Sorted integer set, top level: command port, control and the row of cells.
// Depends on ssi_pkg and ssi_cell.
//
// The block keeps up to SET_CAPACITY distinct signed values in ascending order in a row
// of cells, one entry per cell. A transaction is taken when start is high and busy is low.
// Every cell compares its entry against the value in the cycle after start; in the next
// cycle the hit and position are known and all cells shift together for an insert or a
// remove. The result is registered after the shift stage and driven onto the out_ ports
// for exactly one cycle with out_valid high, and cannot be held off. Busy is high for
// one cycle after each start, so a new transaction can be taken while the previous one
// is still in its shift stage.
`default_nettype none

module sorted_integer_set
  import ssi_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_cmd,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_valid,
  output logic                         out_was_member,
  output logic [1:0]                   out_status,
  output logic [OUT_CNT_W-1:0]         out_member_count
);

  logic                    s1_r, s1_nxt;
  logic                    s2_r, s2_nxt;
  ssi_cmd_t                cmd_r;
  logic signed [VAL_W-1:0] value_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    was_member_r;
  ssi_status_t             status_r, status_nxt;
  logic [CNT_W-1:0]        out_count_r;

  ssi_ctl_t                ctl;
  logic                    hit;
  logic                    full;
  logic                    accept;

  logic signed [VAL_W-1:0] cell_data [SET_CAPACITY];
  logic [SET_CAPACITY-1:0] cell_lt;
  logic [SET_CAPACITY-1:0] cell_eq;

  assign accept = start && !s1_r;
  assign busy   = s1_r;
  assign hit    = |cell_eq;
  assign full   = (count_r == CNT_W'(SET_CAPACITY));

  // Sequencing: compare in stage s1, then decide and shift in stage s2.
  always_comb begin
    s1_nxt        = accept;
    s2_nxt        = s1_r;
    ctl.cmp       = s1_r;
    ctl.ins       = 1'b0;
    ctl.del       = 1'b0;
    count_nxt     = count_r;
    status_nxt    = ST_NO_CHANGE;
    out_valid_nxt = s2_r;
    if (s2_r) begin
      unique case (cmd_r)
        CMD_INSERT: begin
          if (!hit) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.ins    = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = ST_CHANGED;
            end
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            ctl.del    = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = ST_CHANGED;
          end
        end
        default: begin
          status_nxt = ST_NO_CHANGE;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Transaction and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= ssi_cmd_t'(in_cmd);
      value_r <= in_value;
    end
    if (s2_r) begin
      was_member_r <= hit;
      status_r     <= status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  // The row of cells; cell 0 sees a virtual left neighbor that is always less.
  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic                    left_l;
    logic signed [VAL_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[0];
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_l = cell_lt[i-1];
    end
    if (i == SET_CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    ssi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (value_r),
      .cell_valid (CNT_W'(i) < count_r),
      .left_data  (left_d),
      .left_lt    (left_l),
      .right_data (right_d),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_was_member   = was_member_r;
  assign out_status       = status_r;
  assign out_member_count = OUT_CNT_W'(out_count_r);

endmodule

`default_nettype wire

/* sv/ssi_cell.sv */
// One cell of the sorted chain: holds one entry and its compare flags, and
// shifts with its neighbors on insert and remove. Depends on ssi_pkg.
`default_nettype none

module ssi_cell
  import ssi_pkg::*;
(
  input  wire logic                    clk,
  input  wire ssi_ctl_t                ctl,
  input  wire logic signed [VAL_W-1:0] key,
  input  wire logic                    cell_valid,
  input  wire logic signed [VAL_W-1:0] left_data,
  input  wire logic                    left_lt,
  input  wire logic signed [VAL_W-1:0] right_data,
  output logic signed [VAL_W-1:0]      data,
  output logic                         lt,
  output logic                         eq
);

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic                    lt_r, lt_nxt;
  logic                    eq_r, eq_nxt;

  // Compare phase sets the flags; update phase shifts or writes the entry.
  always_comb begin
    lt_nxt   = lt_r;
    eq_nxt   = eq_r;
    data_nxt = data_r;
    if (ctl.cmp) begin
      lt_nxt = cell_valid && (data_r < key);
      eq_nxt = cell_valid && (data_r == key);
    end
    if (ctl.ins) begin
      if (!left_lt) begin
        data_nxt = left_data;
      end else if (!lt_r) begin
        data_nxt = key;
      end
    end else if (ctl.del) begin
      if (!lt_r) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    lt_r   <= lt_nxt;
    eq_r   <= eq_nxt;
  end

  assign data = data_r;
  assign lt   = lt_r;
  assign eq   = eq_r;

endmodule

`default_nettype wire

/* sv/ssi_checker.sv */
// Port-level checker for the sorted integer set, bound to the top level.
// Depends on ssi_pkg and sorted_integer_set.
`default_nettype none

module ssi_checker
  import ssi_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    out_valid,
  input wire logic                    out_was_member,
  input wire logic [1:0]              out_status,
  input wire logic [OUT_CNT_W-1:0]    out_member_count
);

  // A taken transaction raises busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a transaction was taken");

  // Every taken transaction yields its result after the s1, s2 and output valid registers.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("result missing three cycles after a transaction");

  // Results are never back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A refused insert reports a full store and a non-member.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
      !out_was_member && (out_member_count == OUT_CNT_W'(SET_CAPACITY)))
    else $error("full status with inconsistent member flag or count");

endmodule

bind sorted_integer_set ssi_checker u_ssi_checker (.*);

`default_nettype wire
